/* rtl/core/gda_pkg.sv */
// Package for the Gregorian date adder: item types, sequencer states,
// control/status structs and calendar helper functions. No dependencies.
package gda_pkg;

    localparam int unsigned NW = 22;   // day offset width
    localparam int unsigned YW = 15;   // internal year width (end_year wraps at 14 bits)

    localparam logic [NW-1:0] CycleDays   = 22'd146097;  // days in 400 years
    localparam logic [YW-1:0] CycleYears  = 15'd400;
    localparam logic [NW-1:0] CycleYearsN = 22'd400;
    localparam logic [YW-1:0] LastCycYear = 15'd399;
    localparam logic [3:0]    LastMonth   = 4'd12;

    typedef struct packed {
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [20:0] day_count;
    } query_t;

    typedef struct packed {
        logic [13:0] end_year;
        logic [3:0]  end_month;
        logic [4:0]  end_day;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,      // year mod 400
        ST_CLAMP,    // clamp day, add day offset
        ST_PREFIX,   // add lengths of months before start month
        ST_CYCLE,    // strip 400-year cycles
        ST_YEAR,     // strip single years
        ST_MONTH     // strip months, then emit
    } state_t;

    typedef struct packed {
        state_t phase;
        logic   load;
        logic   step;    // commit ALU result for this phase
        logic   finish;  // capture result item
    } ctrl_t;

    typedef struct packed {
        logic ge;    // ALU minuend >= subtrahend
        logic more;  // month index below its limit
    } status_t;

    // r is the year mod 400
    function automatic logic leap_of(input logic [YW-1:0] r);
        leap_of = (r[1:0] == 2'd0) && (r != 15'd100) && (r != 15'd200) && (r != 15'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        case (m)
            4'd2:                      month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

    function automatic logic [NW-1:0] year_len(input logic leap);
        year_len = leap ? 22'd366 : 22'd365;
    endfunction

endpackage

/* rtl/core/gda_alu.sv */
// Shared add/subtract unit of the date adder, with unsigned compare.
// Depends on gda_pkg.
module gda_alu (
    input  logic [gda_pkg::NW-1:0] a,
    input  logic [gda_pkg::NW-1:0] b,
    input  logic                   sub,
    output logic [gda_pkg::NW-1:0] sum,
    output logic                   ge
);

    logic [gda_pkg::NW:0] full;
    logic [gda_pkg::NW-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign full = {1'b0, a} + {1'b0, b_op} + {{gda_pkg::NW{1'b0}}, sub};
    assign sum  = full[gda_pkg::NW-1:0];
    assign ge   = full[gda_pkg::NW];   // no borrow on subtract

endmodule

/* rtl/core/gda_seq.sv */
// Sequencer of the date adder: steps through the reduction phases.
// Depends on gda_pkg.
module gda_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  gda_pkg::status_t status,
    output gda_pkg::ctrl_t   ctrl,
    output logic             busy
);

    gda_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl.phase  = state_reg;
        ctrl.load   = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.finish = 1'b0;
        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = gda_pkg::ST_MOD;
                end
            end
            gda_pkg::ST_MOD:
            begin
                if (status.ge) ctrl.step = 1'b1;
                else           state_next = gda_pkg::ST_CLAMP;
            end
            gda_pkg::ST_CLAMP:
            begin
                ctrl.step  = 1'b1;
                state_next = gda_pkg::ST_PREFIX;
            end
            gda_pkg::ST_PREFIX:
            begin
                if (status.more) ctrl.step = 1'b1;
                else             state_next = gda_pkg::ST_CYCLE;
            end
            gda_pkg::ST_CYCLE:
            begin
                if (status.ge) ctrl.step = 1'b1;
                else           state_next = gda_pkg::ST_YEAR;
            end
            gda_pkg::ST_YEAR:
            begin
                if (status.ge) ctrl.step = 1'b1;
                else           state_next = gda_pkg::ST_MONTH;
            end
            gda_pkg::ST_MONTH:
            begin
                if (status.more && status.ge)
                begin
                    ctrl.step = 1'b1;
                end
                else
                begin
                    ctrl.finish = 1'b1;
                    state_next  = gda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != gda_pkg::ST_IDLE);

endmodule

/* rtl/core/gregorian_date_add_days.sv */
// Top level of the Gregorian date adder: datapath registers and result
// register. Depends on gda_pkg, gda_alu and gda_seq.
//
// Adds day_count days to a Gregorian date. An item is taken when start is
// high and busy is low; the result shows on result for exactly one cycle
// with done high, and must be captured then, since the block cannot be
// held off. An item goes through these steps in order: year mod 400 by
// repeated subtraction of 400 from start_year, clamp of the start day,
// one addition per month before start_month, one subtraction per 400-year
// cycle in the count, one per remaining year (at most 400) and one per
// month of the final year. All of these steps share a single 22-bit
// add/subtract unit. busy drops in the cycle that done is high, so the
// next item may be given then. Out-of-range start fields are clamped
// (year 0 as 1, month to 1..12, day to 1..month length); end_year wraps
// modulo 16384.
module gregorian_date_add_days (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  gda_pkg::query_t  query,
    output logic             busy,
    output logic             done,
    output gda_pkg::result_t result
);

    // working state
    logic [gda_pkg::YW-1:0] y_reg;      // running year
    logic [gda_pkg::YW-1:0] r_reg;      // year mod 400 (after the mod phase)
    logic [3:0]             m_reg;      // clamped start month
    logic [3:0]             i_reg;      // month index
    logic [4:0]             d_reg;      // raw start day
    logic [gda_pkg::NW-1:0] n_reg;      // day offset
    gda_pkg::result_t       res_reg;
    logic                   done_reg;

    gda_pkg::ctrl_t   ctrl;
    gda_pkg::status_t status;

    logic [gda_pkg::NW-1:0] alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_ge;
    logic                   leap;
    logic [4:0]             ml_start, ml_idx, d_clamp;
    logic [13:0]            y_in;
    logic [3:0]             m_in;

    gda_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    gda_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    // leap flag is meaningful once r_reg < 400
    assign leap     = gda_pkg::leap_of(r_reg);
    assign ml_start = gda_pkg::month_len(leap, m_reg);
    assign ml_idx   = gda_pkg::month_len(leap, i_reg);

    always_comb
    begin
        if (d_reg == 5'd0)         d_clamp = 5'd1;
        else if (d_reg > ml_start) d_clamp = ml_start;
        else                       d_clamp = d_reg;
    end

    // input clamping
    assign y_in = (query.start_year == 14'd0) ? 14'd1 : query.start_year;
    always_comb
    begin
        if (query.start_month == 4'd0)                     m_in = 4'd1;
        else if (query.start_month > gda_pkg::LastMonth)   m_in = gda_pkg::LastMonth;
        else                                               m_in = query.start_month;
    end

    // operand select for the shared unit
    always_comb
    begin
        alu_a   = n_reg;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (ctrl.phase)
            gda_pkg::ST_MOD:
            begin
                alu_a = {{(gda_pkg::NW-gda_pkg::YW){1'b0}}, r_reg};
                alu_b = gda_pkg::CycleYearsN;
            end
            gda_pkg::ST_CLAMP:
            begin
                alu_b   = {{(gda_pkg::NW-5){1'b0}}, d_clamp - 5'd1};
                alu_sub = 1'b0;
            end
            gda_pkg::ST_PREFIX:
            begin
                alu_b   = {{(gda_pkg::NW-5){1'b0}}, ml_idx};
                alu_sub = 1'b0;
            end
            gda_pkg::ST_CYCLE: alu_b = gda_pkg::CycleDays;
            gda_pkg::ST_YEAR:  alu_b = gda_pkg::year_len(leap);
            gda_pkg::ST_MONTH: alu_b = {{(gda_pkg::NW-5){1'b0}}, ml_idx};
            default:           alu_b = '0;
        endcase
    end

    assign status.ge   = alu_ge;
    assign status.more = (ctrl.phase == gda_pkg::ST_PREFIX) ? (i_reg < m_reg)
                                                            : (i_reg < gda_pkg::LastMonth);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            y_reg <= {1'b0, y_in};
            r_reg <= {1'b0, y_in};
            m_reg <= m_in;
            i_reg <= 4'd1;
            d_reg <= query.start_day;
            n_reg <= {1'b0, query.day_count};
        end
        else if (ctrl.step)
        begin
            case (ctrl.phase)
                gda_pkg::ST_MOD:
                begin
                    r_reg <= alu_sum[gda_pkg::YW-1:0];
                end
                gda_pkg::ST_CLAMP:
                begin
                    n_reg <= alu_sum;
                end
                gda_pkg::ST_PREFIX:
                begin
                    n_reg <= alu_sum;
                    i_reg <= i_reg + 4'd1;
                end
                gda_pkg::ST_CYCLE:
                begin
                    n_reg <= alu_sum;
                    y_reg <= y_reg + gda_pkg::CycleYears;
                end
                gda_pkg::ST_YEAR:
                begin
                    n_reg <= alu_sum;
                    y_reg <= y_reg + 15'd1;
                    r_reg <= (r_reg == gda_pkg::LastCycYear) ? '0 : r_reg + 15'd1;
                end
                gda_pkg::ST_MONTH:
                begin
                    n_reg <= alu_sum;
                    i_reg <= i_reg + 4'd1;
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
        else if (ctrl.phase == gda_pkg::ST_YEAR)
        begin
            // year found: restart month index for the final walk
            i_reg <= 4'd1;
        end

        if (ctrl.finish)
        begin
            res_reg.end_year  <= y_reg[13:0];
            res_reg.end_month <= i_reg;
            res_reg.end_day   <= n_reg[4:0] + 5'd1;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* tb/gregorian_date_add_days_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for gregorian_date_add_days (date plus day count).
// Depends on gda_pkg for the query and result item types and on the design under test.
module gregorian_date_add_days_tb;

    // Calendar constants for the local date predictor
    localparam int unsigned DAYS_PER_CYCLE  = 146097;  // days in 400 Gregorian years
    localparam int unsigned YEARS_PER_CYCLE = 400;
    localparam int unsigned FEB = 2;
    localparam int unsigned APR = 4;
    localparam int unsigned JUN = 6;
    localparam int unsigned SEP = 9;
    localparam int unsigned NOV = 11;
    localparam int unsigned DEC = 12;

    localparam int NUM_DIRECTED = 24;
    localparam int NUM_RANDOM   = 600;
    localparam int SETTLE_CYCLES = 600;

    // One row of the directed table. typed rows carry a hand-written answer;
    // the others are checked against the predictor.
    typedef struct packed {
        gda_pkg::query_t  q;
        bit               typed;
        gda_pkg::result_t want;
    } date_case_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    gda_pkg::query_t  query;
    logic             busy;
    logic             done;
    gda_pkg::result_t result;

    gda_pkg::result_t expected_dates [$];   // pending end dates, oldest first
    gda_pkg::result_t due_date;
    int unsigned      mismatches;
    int unsigned      dates_sent;
    int unsigned      dates_checked;
    int unsigned      odd_starts;

    // Directed cases: identity, clamping of every field, leap-rule corners,
    // year rollover, a full 400-year cycle, year wrap past 14 bits and the
    // all-ones count.
    date_case_t directed_cases [NUM_DIRECTED] = '{
        '{'{14'd2000,  4'd1,  5'd1,  21'd0},       1'b1, '{14'd2000,  4'd1,  5'd1}},
        '{'{14'd0,     4'd0,  5'd0,  21'd0},       1'b1, '{14'd1,     4'd1,  5'd1}},
        '{'{14'd1,     4'd15, 5'd31, 21'd0},       1'b1, '{14'd1,     4'd12, 5'd31}},
        '{'{14'd2023,  4'd2,  5'd29, 21'd0},       1'b1, '{14'd2023,  4'd2,  5'd28}},
        '{'{14'd2024,  4'd2,  5'd31, 21'd0},       1'b1, '{14'd2024,  4'd2,  5'd29}},
        '{'{14'd2023,  4'd4,  5'd31, 21'd0},       1'b1, '{14'd2023,  4'd4,  5'd30}},
        '{'{14'd2020,  4'd5,  5'd0,  21'd0},       1'b1, '{14'd2020,  4'd5,  5'd1}},
        '{'{14'd2023,  4'd13, 5'd1,  21'd0},       1'b1, '{14'd2023,  4'd12, 5'd1}},
        '{'{14'd1999,  4'd12, 5'd31, 21'd1},       1'b1, '{14'd2000,  4'd1,  5'd1}},
        '{'{14'd2000,  4'd2,  5'd28, 21'd1},       1'b1, '{14'd2000,  4'd2,  5'd29}},
        '{'{14'd1900,  4'd2,  5'd28, 21'd1},       1'b1, '{14'd1900,  4'd3,  5'd1}},
        '{'{14'd2100,  4'd2,  5'd28, 21'd1},       1'b1, '{14'd2100,  4'd3,  5'd1}},
        '{'{14'd2024,  4'd12, 5'd31, 21'd1},       1'b1, '{14'd2025,  4'd1,  5'd1}},
        '{'{14'd1,     4'd1,  5'd1,  21'd365},     1'b1, '{14'd2,     4'd1,  5'd1}},
        '{'{14'd2000,  4'd1,  5'd1,  21'd146097},  1'b1, '{14'd2400,  4'd1,  5'd1}},
        '{'{14'd1600,  4'd2,  5'd29, 21'd146097},  1'b1, '{14'd2000,  4'd2,  5'd29}},
        '{'{14'd16383, 4'd12, 5'd31, 21'd0},       1'b1, '{14'd16383, 4'd12, 5'd31}},
        '{'{14'd16383, 4'd12, 5'd31, 21'd1},       1'b1, '{14'd0,     4'd1,  5'd1}},
        '{'{14'd9999,  4'd12, 5'd31, 21'd2097151}, 1'b0, '0},
        '{'{14'd1,     4'd1,  5'd1,  21'd2097151}, 1'b0, '0},
        '{'{14'd16383, 4'd15, 5'd31, 21'd2097151}, 1'b0, '0},
        '{'{14'd2024,  4'd3,  5'd1,  21'd365},     1'b0, '0},
        '{'{14'd2000,  4'd12, 5'd31, 21'd146096},  1'b0, '0},
        '{'{14'd8191,  4'd8,  5'd16, 21'd1048576}, 1'b0, '0}
    };

    gregorian_date_add_days DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .query  (query),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Date predictor
    // ---------------------------------------------------------------
    function automatic bit is_leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
        case (mo)
            FEB:                return is_leap_year(yr) ? 29 : 28;
            APR, JUN, SEP, NOV: return 30;
            default:            return 31;
        endcase
    endfunction

    // Clamp the start date, turn it into a day offset within its year, then
    // peel off 400-year cycles, single years and months in that order.
    function automatic gda_pkg::result_t add_days(input gda_pkg::query_t q);
        int unsigned      yr;
        int unsigned      mo;
        int unsigned      dy;
        int unsigned      left;
        int unsigned      k;
        gda_pkg::result_t r;
        yr   = 32'(q.start_year);
        mo   = 32'(q.start_month);
        dy   = 32'(q.start_day);
        left = 32'(q.day_count);
        if (yr == 0)
            yr = 1;
        if (mo == 0)
            mo = 1;
        else if (mo > DEC)
            mo = DEC;
        if (dy == 0)
            dy = 1;
        else if (dy > days_in_month(yr, mo))
            dy = days_in_month(yr, mo);
        left += dy - 1;
        for (k = 1; k < mo; k++)
            left += days_in_month(yr, k);
        while (left >= DAYS_PER_CYCLE)
        begin
            left -= DAYS_PER_CYCLE;
            yr   += YEARS_PER_CYCLE;
        end
        while (left >= (is_leap_year(yr) ? 366 : 365))
        begin
            left -= is_leap_year(yr) ? 366 : 365;
            yr   += 1;
        end
        mo = 1;
        while (mo < DEC && left >= days_in_month(yr, mo))
        begin
            left -= days_in_month(yr, mo);
            mo   += 1;
        end
        r.end_year  = 14'(yr);   // wraps modulo 16384
        r.end_month = 4'(mo);
        r.end_day   = 5'(left + 1);
        return r;
    endfunction

    // Mostly calendar-valid starts with counts of every scale; the tail gives
    // month-end starts and fully random (often out-of-range) fields.
    function automatic gda_pkg::query_t random_date();
        gda_pkg::query_t q;
        int unsigned     pick;
        pick = $urandom_range(99);
        q.start_year  = 14'((pick % 10 == 0) ? $urandom_range(16383, 10000)
                                             : $urandom_range(9999, 1));
        q.start_month = 4'($urandom_range(12, 1));
        q.start_day   = 5'($urandom_range(
                            days_in_month(32'(q.start_year), 32'(q.start_month)), 1));
        if (pick < 35)
            q.day_count = 21'($urandom_range(400));
        else if (pick < 60)
            q.day_count = 21'($urandom_range(20000));
        else if (pick < 80)
            q.day_count = 21'($urandom_range(2097151));
        else if (pick < 88)
        begin
            q.start_day = 5'(days_in_month(32'(q.start_year), 32'(q.start_month)));
            q.day_count = 21'($urandom_range(2));
        end
        else
        begin
            q.start_year  = 14'($urandom_range(16383));
            q.start_month = 4'($urandom_range(15));
            q.start_day   = 5'($urandom_range(31));
            q.day_count   = 21'($urandom_range(2097151));
        end
        return q;
    endfunction

    // ---------------------------------------------------------------
    // Driver side: everything changes on the falling edge
    // ---------------------------------------------------------------

    // Called at a falling edge. busy is a registered output, so its value
    // here is the one the next rising edge sees: once it reads low, the item
    // goes in at that edge. start stays high on return; the next call or an
    // idle cycle decides what it does next.
    task automatic issue_date(input gda_pkg::query_t q, input bit typed,
                              input gda_pkg::result_t want);
        start <= 1'b1;
        query <= q;
        while (busy)
            @(negedge clk);
        expected_dates.push_back(typed ? want : add_days(q));
        dates_sent++;
        @(negedge clk);
    endtask

    // Random gap before an item, junk on the query bus while start is low
    task automatic idle_gap(input int unsigned pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            query <= 44'({$urandom, $urandom});
            @(negedge clk);
        end
    endtask

    // Hold off until every outstanding date has come back
    task automatic drain_dates();
        start <= 1'b0;
        @(negedge clk);
        while (expected_dates.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (done)
        begin
            if (expected_dates.size() == 0)
                report_mismatch($sformatf("result %0d-%0d-%0d with nothing pending",
                    result.end_year, result.end_month, result.end_day));
            else
            begin
                due_date = expected_dates.pop_front();
                dates_checked++;
                if (result.end_year != due_date.end_year)
                    report_mismatch($sformatf("end_year %0d, want %0d",
                        result.end_year, due_date.end_year));
                if (result.end_month != due_date.end_month)
                    report_mismatch($sformatf("end_month %0d, want %0d",
                        result.end_month, due_date.end_month));
                if (result.end_day != due_date.end_day)
                    report_mismatch($sformatf("end_day %0d, want %0d",
                        result.end_day, due_date.end_day));
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int               n;
        int unsigned      idle_pct;
        gda_pkg::query_t  q;
        rst_n         = 1'b0;
        start         = 1'b0;
        query         = '0;
        mismatches    = 0;
        dates_sent    = 0;
        dates_checked = 0;
        odd_starts    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (n = 0; n < NUM_DIRECTED; n++)
        begin
            idle_gap(22);
            issue_date(directed_cases[n].q, directed_cases[n].typed, directed_cases[n].want);
        end
        drain_dates();

        // random items in three pacing phases: light gaps, heavy gaps,
        // back to back; the block is drained between phases
        for (n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 3 || n == 2 * NUM_RANDOM / 3)
                drain_dates();
            idle_pct = (n < NUM_RANDOM / 3) ? 22 : (n < 2 * NUM_RANDOM / 3) ? 68 : 0;
            idle_gap(idle_pct);
            q = random_date();
            if (q.start_year == 0 || q.start_month == 0 || q.start_month > DEC ||
                q.start_day == 0)
                odd_starts++;
            issue_date(q, 1'b0, '0);
        end

        drain_dates();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d date additions (%0d directed, %0d random, %0d with clamped fields),",
            dates_sent, NUM_DIRECTED, NUM_RANDOM, odd_starts);
        $display("checked %0d results under light, heavy and no start gaps.", dates_checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results still pending", expected_dates.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
